// ===== rtl/trial_division_prime_test_top_defines.svh =====
// Assertion macros shared by the prime test block.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TDPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tdpt assertion failed");

// Consequent checked in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tdpt assertion failed");

`endif

// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

    localparam int CAND_BITS      = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [3:0] {
        STEP_WAIT      = 4'd0,
        STEP_LE1       = 4'd1,
        STEP_EQ2       = 4'd2,
        STEP_EVEN      = 4'd3,
        STEP_DIV_START = 4'd4,
        STEP_DIV_WAIT  = 4'd5,
        STEP_BOUND     = 4'd6,
        STEP_REM       = 4'd7,
        STEP_NEXT_D    = 4'd8,
        STEP_EMIT      = 4'd9
    } t_step;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_LE1,
        C_EQ2,
        C_EVEN,
        C_DIV_IDLE,
        C_D_GT_Q,
        C_R_ZERO,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [2:0] {
        A_NONE,
        A_LOAD,
        A_SET0,
        A_SET1,
        A_DIV_START,
        A_D_ADD2,
        A_EMIT
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_act  act;
        t_step on_true;
        t_step on_false;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic le1;
        logic eq2;
        logic even;
        logic div_idle;
        logic d_gt_q;
        logic r_zero;
        logic out_free;
    } t_flags;

    function automatic t_uword rom_word(input t_step step);
        t_uword w;
        case (step)
            STEP_WAIT:      w = '{C_ACCEPT,   A_LOAD,      STEP_LE1,       STEP_WAIT};
            STEP_LE1:       w = '{C_LE1,      A_SET0,      STEP_EMIT,      STEP_EQ2};
            STEP_EQ2:       w = '{C_EQ2,      A_SET1,      STEP_EMIT,      STEP_EVEN};
            STEP_EVEN:      w = '{C_EVEN,     A_SET0,      STEP_EMIT,      STEP_DIV_START};
            STEP_DIV_START: w = '{C_ALWAYS,   A_DIV_START, STEP_DIV_WAIT,  STEP_DIV_WAIT};
            STEP_DIV_WAIT:  w = '{C_DIV_IDLE, A_NONE,      STEP_BOUND,     STEP_DIV_WAIT};
            STEP_BOUND:     w = '{C_D_GT_Q,   A_SET1,      STEP_EMIT,      STEP_REM};
            STEP_REM:       w = '{C_R_ZERO,   A_SET0,      STEP_EMIT,      STEP_NEXT_D};
            STEP_NEXT_D:    w = '{C_ALWAYS,   A_D_ADD2,    STEP_DIV_START, STEP_DIV_START};
            STEP_EMIT:      w = '{C_OUT_FREE, A_EMIT,      STEP_WAIT,      STEP_EMIT};
            default:        w = '{C_ALWAYS,   A_NONE,      STEP_WAIT,      STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/trial_division_prime_test_top.sv =====
// channel | valid      | stall       | payload
// --------+------------+-------------+-------------
// in      | i_in_valid | o_in_stall  | i_candidate
// out     | o_out_valid| i_out_stall | o_is_prime
//
// One beat in, one beat out. Values below 3 and even values finish without the divider.
// Odd values try odd divisors from 3 upward, up to sqrt(candidate) / 2 of them, each
// through the shared one-bit-a-cycle divider.
// Reset is synchronous and clears the step counter and the output valid.
// A stalled output holds the sequencer at its emit step; no new beat is taken until then.
module trial_division_prime_test_top #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tdpt_pkg::CAND_BITS-1:0] i_candidate,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_is_prime
);

    `include "trial_division_prime_test_top_defines.svh"

    logic [VALUE_BITS-1:0] w_cand;
    logic [VALUE_BITS-1:0] r_n;
    logic [VALUE_BITS-1:0] r_d;
    logic                  r_result;
    logic                  r_out_valid;
    logic                  r_out_prime;
    logic [VALUE_BITS-1:0] w_quo;
    logic [VALUE_BITS-1:0] w_rem;
    logic                  w_div_busy;
    tdpt_pkg::t_flags      w_flags;
    tdpt_pkg::t_act        w_act;
    tdpt_pkg::t_step       w_step;

    if (VALUE_BITS > tdpt_pkg::CAND_BITS) begin : g_extend
        assign w_cand = {{(VALUE_BITS - tdpt_pkg::CAND_BITS){1'b0}}, i_candidate};
    end else if (VALUE_BITS == tdpt_pkg::CAND_BITS) begin : g_same
        assign w_cand = i_candidate;
    end else begin : g_trim
        assign w_cand = i_candidate[VALUE_BITS-1:0];
    end

    assign o_in_stall = (w_step != tdpt_pkg::STEP_WAIT);

    always_comb begin
        w_flags.accept   = i_in_valid;
        w_flags.le1      = (r_n[VALUE_BITS-1:1] == '0);
        w_flags.eq2      = (r_n == VALUE_BITS'(2));
        w_flags.even     = !r_n[0];
        w_flags.div_idle = !w_div_busy;
        w_flags.d_gt_q   = (r_d > w_quo);
        w_flags.r_zero   = (w_rem == '0);
        w_flags.out_free = !r_out_valid || !i_out_stall;
    end

    tdpt_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_act   (w_act),
        .o_step  (w_step)
    );

    tdpt_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_act == tdpt_pkg::A_DIV_START),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_busy      (w_div_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        case (w_act)
            tdpt_pkg::A_LOAD: begin
                r_n <= w_cand;
                r_d <= VALUE_BITS'(3);
            end
            tdpt_pkg::A_SET0:   r_result <= 1'b0;
            tdpt_pkg::A_SET1:   r_result <= 1'b1;
            tdpt_pkg::A_D_ADD2: r_d <= r_d + VALUE_BITS'(2);
            tdpt_pkg::A_EMIT:   r_out_prime <= r_result;
            default: begin
            end
        endcase
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_act == tdpt_pkg::A_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

    `TDPT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `TDPT_ASSERT_NOW(a_valid_from_emit, $rose(o_out_valid), $past(w_act == tdpt_pkg::A_EMIT))
    `TDPT_ASSERT_NOW(a_div_start_idle, w_act == tdpt_pkg::A_DIV_START, !w_div_busy)

endmodule

// ===== rtl/tdpt_divider.sv =====
module tdpt_divider #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_busy,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [VALUE_BITS-1:0] o_remainder
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [VALUE_BITS-1:0] r_div;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic [VALUE_BITS:0]   w_shift;
    logic [VALUE_BITS+1:0] w_sub;

    assign w_shift = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_sub   = {1'b0, w_shift} - {2'b00, r_div};

    always_comb begin
        if (!w_sub[VALUE_BITS+1]) begin
            n_rem = w_sub[VALUE_BITS-1:0];
            n_quo = {r_quo[VALUE_BITS-2:0], 1'b1};
        end else begin
            n_rem = w_shift[VALUE_BITS-1:0];
            n_quo = {r_quo[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(VALUE_BITS);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_cnt  <= r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/tdpt_sequencer.sv =====
module tdpt_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tdpt_pkg::t_flags i_flags,
    output tdpt_pkg::t_act   o_act,
    output tdpt_pkg::t_step  o_step
);

    tdpt_pkg::t_step  r_pc, n_pc;
    tdpt_pkg::t_uword w_word;
    logic             w_take;

    assign w_word = tdpt_pkg::rom_word(r_pc);

    always_comb begin
        case (w_word.cond)
            tdpt_pkg::C_ALWAYS:   w_take = 1'b1;
            tdpt_pkg::C_ACCEPT:   w_take = i_flags.accept;
            tdpt_pkg::C_LE1:      w_take = i_flags.le1;
            tdpt_pkg::C_EQ2:      w_take = i_flags.eq2;
            tdpt_pkg::C_EVEN:     w_take = i_flags.even;
            tdpt_pkg::C_DIV_IDLE: w_take = i_flags.div_idle;
            tdpt_pkg::C_D_GT_Q:   w_take = i_flags.d_gt_q;
            tdpt_pkg::C_R_ZERO:   w_take = i_flags.r_zero;
            tdpt_pkg::C_OUT_FREE: w_take = i_flags.out_free;
            default:              w_take = 1'b0;
        endcase
        n_pc  = w_take ? w_word.on_true : w_word.on_false;
        o_act = w_take ? w_word.act : tdpt_pkg::A_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tdpt_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_step = r_pc;

endmodule

// ===== test/testbench.sv =====
module testbench;

    localparam int          CAND_BITS    = tdpt_pkg::CAND_BITS;
    localparam int          WIDTH        = tdpt_pkg::VALUE_BITS_DEF;
    localparam int unsigned STALL_LIMIT  = 200000;
    localparam int unsigned MAX_DIVISORS = 300;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned LONG_HOLD    = 30000;
    localparam int          REPORT_LIMIT = 10;

    typedef struct {
        logic [CAND_BITS-1:0] candidate;
        bit                   prime;
    } t_prime_verdict;

    class prime_scoreboard;
        t_prime_verdict verdict_q[$];
        int unsigned    mismatches;
        int unsigned    beats_in;
        int unsigned    primes_in;
        int unsigned    beats_out;

        function void trial_divide(input logic [CAND_BITS-1:0] cand, output bit prime,
                                   output int unsigned divisors);
            longint unsigned n;
            longint unsigned d;
            n = longint'(cand) & (((64'd1 << (WIDTH - 1)) << 1) - 64'd1);
            prime    = 1'b0;
            divisors = 0;
            if (n <= 1)
                return;
            if (n == 2) begin
                prime = 1'b1;
                return;
            end
            if (n[0] == 1'b0)
                return;
            prime = 1'b1;
            for (d = 3; d <= n / d; d += 2) begin
                divisors++;
                if (n % d == 0) begin
                    prime = 1'b0;
                    return;
                end
            end
        endfunction

        function void note_candidate(input logic [CAND_BITS-1:0] cand);
            t_prime_verdict v;
            int unsigned    divisors;
            v.candidate = cand;
            trial_divide(cand, v.prime, divisors);
            verdict_q.push_back(v);
            beats_in++;
            if (v.prime)
                primes_in++;
        endfunction

        function void check_result(input logic got);
            t_prime_verdict v;
            beats_out++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: is_prime=%0b", got);
                return;
            end
            v = verdict_q.pop_front();
            if (got !== v.prime) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("is_prime mismatch for %0d (0x%08h): expected %0b, got %0b",
                             v.candidate, v.candidate, v.prime, got);
            end
        endfunction
    endclass

    bit                   i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [CAND_BITS-1:0] i_candidate;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_is_prime;

    prime_scoreboard sb = new();
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     hold_left;
    int unsigned     quiet_cycles;

    trial_division_prime_test_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_candidate (i_candidate),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_is_prime  (o_is_prime)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stall the output at random, or hold it off for a long stretch when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_is_prime);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_candidate(input logic [CAND_BITS-1:0] cand);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_candidate <= cand;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_candidate(cand);
    endtask

    // keep the search short: skip values that need too many trial divisors
    function automatic logic [CAND_BITS-1:0] pick_candidate();
        logic [CAND_BITS-1:0] cand;
        bit                   prime;
        int unsigned          divisors;
        do begin
            case ($urandom_range(0, 3))
                0:       cand = $urandom_range(0, 63);
                1:       cand = $urandom_range(0, 65535);
                2:       cand = $urandom;
                default: cand = $urandom | 32'h1;
            endcase
            sb.trial_divide(cand, prime, divisors);
        end while (divisors > MAX_DIVISORS);
        return cand;
    endfunction

    task automatic run_random(input int unsigned beats, input int unsigned tx_pct,
                              input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (beats)
            send_candidate(pick_candidate());
    endtask

    initial begin
        logic [CAND_BITS-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
                     32'd49, 32'd91, 32'd97, 32'd121, 32'd65521, 32'd65535, 32'd1042441,
                     32'd1048573, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                     32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_candidate  = '0;
        i_out_stall  = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k])
            send_candidate(directed[k]);

        run_random(26, 15, 83);
        run_random(26, 83, 15);
        hold_left = LONG_HOLD;
        run_random(25, 0, 0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Tested %0d candidates (%0d prime, %0d results seen): edge values, squares,",
                 sb.beats_in, sb.primes_in, sb.beats_out);
        $display("wide values with small factors, three idling mixes and a long output hold.");
        if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.verdict_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tdpt_pkg.sv
rtl/tdpt_divider.sv
rtl/tdpt_sequencer.sv
rtl/trial_division_prime_test_top.sv
test/testbench.sv
